[hdl/stp_pkg.sv]
// Package for the spanning-tree root election block.
// Sizes, command/role/state codes and the priority vector type; no dependencies.
package stp_pkg;

  localparam int NUM_PORTS  = 4;   // ports on the bridge, 1..4
  localparam int COST_WIDTH = 16;  // per-port path cost width, 8..32

  localparam int MAC_W     = 48;
  localparam int PRI_W     = 16;
  localparam int RCOST_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int PORT_W    = 2;
  localparam int PIU_W     = 3;
  localparam int VEC_W     = 8;
  localparam int TABLE_W   = 64;

  // port count wide enough for both ports_in_use and NUM_PORTS
  localparam int CNT_W = ($clog2(NUM_PORTS + 1) > PIU_W) ? $clog2(NUM_PORTS + 1) : PIU_W;
  // ports reported in the role/status vectors
  localparam int VEC_PORTS = (NUM_PORTS < 4) ? NUM_PORTS : 4;

  localparam logic [PRI_W-1:0] OWN_PRI_RST = PRI_W'(32768);
  localparam logic [PIU_W-1:0] PORTS_RST   = PIU_W'(4);

  typedef enum logic [1:0] {
    CMD_INIT      = 2'd0,
    CMD_RX_BPDU   = 2'd1,
    CMD_RECOMPUTE = 2'd2,
    CMD_DISABLE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ROLE_UNKNOWN    = 2'd0,
    ROLE_ROOT       = 2'd1,
    ROLE_DESIGNATED = 2'd2,
    ROLE_BLOCKED    = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    ST_DISABLED   = 2'd0,
    ST_BLOCKING   = 2'd1,
    ST_FORWARDING = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_MAC    = 2'd0,
    CFG_OWN_PRI    = 2'd1,
    CFG_PORTS      = 2'd2,
    CFG_COST_TABLE = 2'd3
  } cfg_idx_e;

  // priority vector, most significant field first
  typedef struct packed {
    logic [PRI_W-1:0]   rt_pri;
    logic [MAC_W-1:0]   rt_mac;
    logic [RCOST_W-1:0] cost;
    logic [PRI_W-1:0]   br_pri;
    logic [MAC_W-1:0]   br_mac;
  } prio_vec_t;

endpackage

[hdl/stp_if.sv]
// Valid/ready channel interfaces for BPDU items and election results.
// Depends on stp_pkg for field widths.
interface stp_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic [stp_pkg::PORT_W-1:0]  rx_port;
  logic [stp_pkg::PRI_W-1:0]   bpdu_root_priority;
  logic [stp_pkg::MAC_W-1:0]   bpdu_root_mac;
  logic [stp_pkg::RCOST_W-1:0] bpdu_root_cost;
  logic [stp_pkg::PRI_W-1:0]   bpdu_sender_priority;
  logic [stp_pkg::MAC_W-1:0]   bpdu_sender_mac;

  modport source (
    output valid, cmd, rx_port, bpdu_root_priority, bpdu_root_mac, bpdu_root_cost,
           bpdu_sender_priority, bpdu_sender_mac,
    input  ready
  );
  modport sink (
    input  valid, cmd, rx_port, bpdu_root_priority, bpdu_root_mac, bpdu_root_cost,
           bpdu_sender_priority, bpdu_sender_mac,
    output ready
  );
endinterface

interface stp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [stp_pkg::MAC_W-1:0]   cur_root_mac;
  logic [stp_pkg::PRI_W-1:0]   cur_root_priority;
  logic [stp_pkg::RCOST_W-1:0] cur_root_cost;
  logic                        has_root_port;
  logic [stp_pkg::PORT_W-1:0]  cur_root_port;
  logic [stp_pkg::VEC_W-1:0]   role_vector;
  logic [stp_pkg::VEC_W-1:0]   status_vector;

  modport source (
    output valid, accepted, cur_root_mac, cur_root_priority, cur_root_cost,
           has_root_port, cur_root_port, role_vector, status_vector,
    input  ready
  );
  modport sink (
    input  valid, accepted, cur_root_mac, cur_root_priority, cur_root_cost,
           has_root_port, cur_root_port, role_vector, status_vector,
    output ready
  );
endinterface

[hdl/stp_bpdu_root_election.sv]
// Spanning-tree root election engine for one bridge.
// Receive port cost is added in front of the input register; compare/update feeds
// the result register. Throughput: one transaction per cycle while out_ch is ready;
// the only loop is the state update.
// Reset (async, active low): own_mac 0, own_priority 32768, 4 ports, costs 0;
// root = own bridge, no root port, roles unknown, all ports blocking.
module stp_bpdu_root_election (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [stp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stp_pkg::CFG_W-1:0]    cfg_wdata_i,
  stp_in_if.sink                       in_ch,
  stp_out_if.source                    out_ch
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [stp_pkg::MAC_W-1:0]   own_mac_q;
  logic [stp_pkg::PRI_W-1:0]   own_pri_q;
  logic [stp_pkg::PIU_W-1:0]   ports_q;
  logic [stp_pkg::TABLE_W-1:0] cost_table_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q    <= '0;
      own_pri_q    <= stp_pkg::OWN_PRI_RST;
      ports_q      <= stp_pkg::PORTS_RST;
      cost_table_q <= '0;
    end else if (cfg_we_i) begin
      case (stp_pkg::cfg_idx_e'(cfg_idx_i))
        stp_pkg::CFG_OWN_MAC:    own_mac_q    <= cfg_wdata_i[stp_pkg::MAC_W-1:0];
        stp_pkg::CFG_OWN_PRI:    own_pri_q    <= cfg_wdata_i[stp_pkg::PRI_W-1:0];
        stp_pkg::CFG_PORTS:      ports_q      <= cfg_wdata_i[stp_pkg::PIU_W-1:0];
        stp_pkg::CFG_COST_TABLE: cost_table_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // active port count: ports_in_use clipped to the physical port count
  logic [stp_pkg::CNT_W-1:0] n_act;
  assign n_act = (stp_pkg::CNT_W'(ports_q) > stp_pkg::CNT_W'(stp_pkg::NUM_PORTS))
               ? stp_pkg::CNT_W'(stp_pkg::NUM_PORTS) : stp_pkg::CNT_W'(ports_q);

  // ---------------------------------------------------------------------------
  // Stage 1: capture transaction, add receive port cost with saturation
  // ---------------------------------------------------------------------------
  typedef struct packed {
    stp_pkg::cmd_e               cmd;
    logic [stp_pkg::PORT_W-1:0]  port;
    logic                        port_ok;
    logic [stp_pkg::PRI_W-1:0]   rp;
    logic [stp_pkg::MAC_W-1:0]   rm;
    logic [stp_pkg::RCOST_W-1:0] cost;
    logic [stp_pkg::PRI_W-1:0]   sp;
    logic [stp_pkg::MAC_W-1:0]   sm;
  } s1_t;

  s1_t  s1_d, s1_q;
  logic s1_valid_q;
  logic adv;        // stage 1 item moves into the result register
  logic out_valid_q;

  assign adv         = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || adv;

  logic [stp_pkg::COST_WIDTH-1:0] port_cost;
  logic [stp_pkg::RCOST_W:0]      cost_sum;

  always_comb begin
    // cost bits that lie beyond the table read as zero
    port_cost = '0;
    for (int i = 0; i < 4; i++) begin
      if (int'(in_ch.rx_port) == i && i * stp_pkg::COST_WIDTH < stp_pkg::TABLE_W) begin
        port_cost = stp_pkg::COST_WIDTH'(cost_table_q >> (i * stp_pkg::COST_WIDTH));
      end
    end
  end

  assign cost_sum = {1'b0, in_ch.bpdu_root_cost} + (stp_pkg::RCOST_W + 1)'(port_cost);

  always_comb begin
    s1_d.cmd     = stp_pkg::cmd_e'(in_ch.cmd);
    s1_d.port    = in_ch.rx_port;
    s1_d.port_ok = stp_pkg::CNT_W'(in_ch.rx_port) < n_act;
    s1_d.rp      = in_ch.bpdu_root_priority;
    s1_d.rm      = in_ch.bpdu_root_mac;
    s1_d.cost    = cost_sum[stp_pkg::RCOST_W] ? '1 : cost_sum[stp_pkg::RCOST_W-1:0];
    s1_d.sp      = in_ch.bpdu_sender_priority;
    s1_d.sm      = in_ch.bpdu_sender_mac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: priority compare, election state update
  // ---------------------------------------------------------------------------
  logic [stp_pkg::MAC_W-1:0]   root_mac_q,  root_mac_d;
  logic [stp_pkg::PRI_W-1:0]   root_pri_q,  root_pri_d;
  logic [stp_pkg::RCOST_W-1:0] path_cost_q, path_cost_d;
  logic                        rpv_q,       rpv_d;
  logic [stp_pkg::PORT_W-1:0]  rp_idx_q,    rp_idx_d;
  stp_pkg::role_e              role_q   [stp_pkg::NUM_PORTS];
  stp_pkg::role_e              role_d   [stp_pkg::NUM_PORTS];
  stp_pkg::status_e            status_q [stp_pkg::NUM_PORTS];
  stp_pkg::status_e            status_d [stp_pkg::NUM_PORTS];

  stp_pkg::prio_vec_t cand_vec, cur_vec;
  logic               better;
  logic               acc_d;
  logic               recomp;
  logic               is_self;

  assign cand_vec = '{rt_pri: s1_q.rp, rt_mac: s1_q.rm, cost: s1_q.cost,
                      br_pri: s1_q.sp, br_mac: s1_q.sm};
  assign cur_vec  = '{rt_pri: root_pri_q, rt_mac: root_mac_q, cost: path_cost_q,
                      br_pri: own_pri_q, br_mac: own_mac_q};

  stp_prio_cmp u_cmp (
    .cand_i   (cand_vec),
    .cur_i    (cur_vec),
    .better_o (better)
  );

  always_comb begin
    root_mac_d  = root_mac_q;
    root_pri_d  = root_pri_q;
    path_cost_d = path_cost_q;
    rpv_d       = rpv_q;
    rp_idx_d    = rp_idx_q;
    for (int i = 0; i < stp_pkg::NUM_PORTS; i++) begin
      role_d[i]   = role_q[i];
      status_d[i] = status_q[i];
    end
    acc_d  = 1'b0;
    recomp = 1'b0;

    case (s1_q.cmd)
      stp_pkg::CMD_INIT: begin
        root_mac_d  = own_mac_q;
        root_pri_d  = own_pri_q;
        path_cost_d = '0;
        rpv_d       = 1'b0;
        rp_idx_d    = '0;
        for (int i = 0; i < stp_pkg::NUM_PORTS; i++) begin
          if (stp_pkg::CNT_W'(i) < n_act) begin
            role_d[i]   = stp_pkg::ROLE_UNKNOWN;
            status_d[i] = stp_pkg::ST_BLOCKING;
          end
        end
      end
      stp_pkg::CMD_RX_BPDU: begin
        // adopt a strictly better vector; receive port becomes root port
        if (s1_q.port_ok && better) begin
          acc_d       = 1'b1;
          recomp      = 1'b1;
          root_mac_d  = s1_q.rm;
          root_pri_d  = s1_q.rp;
          path_cost_d = s1_q.cost;
          rpv_d       = 1'b1;
          rp_idx_d    = s1_q.port;
          for (int i = 0; i < stp_pkg::NUM_PORTS; i++) begin
            if (int'(s1_q.port) == i) begin
              role_d[i]   = stp_pkg::ROLE_ROOT;
              status_d[i] = stp_pkg::ST_FORWARDING;
            end
          end
        end
      end
      stp_pkg::CMD_RECOMPUTE: begin
        recomp = 1'b1;
      end
      stp_pkg::CMD_DISABLE: begin
        for (int i = 0; i < stp_pkg::NUM_PORTS; i++) begin
          if (stp_pkg::CNT_W'(i) < n_act) begin
            status_d[i] = stp_pkg::ST_DISABLED;
          end
        end
      end
      default: ;
    endcase

    // role recompute runs on the post-adoption view
    is_self = (root_mac_d == own_mac_q) && (root_pri_d == own_pri_q);
    if (recomp) begin
      if (is_self) begin
        rpv_d    = 1'b0;
        rp_idx_d = '0;
        for (int i = 0; i < stp_pkg::NUM_PORTS; i++) begin
          if (stp_pkg::CNT_W'(i) < n_act) begin
            role_d[i]   = stp_pkg::ROLE_DESIGNATED;
            status_d[i] = stp_pkg::ST_FORWARDING;
          end
        end
      end else begin
        for (int i = 0; i < stp_pkg::NUM_PORTS; i++) begin
          if (stp_pkg::CNT_W'(i) < n_act && !(rpv_d && int'(rp_idx_d) == i)) begin
            role_d[i]   = stp_pkg::ROLE_BLOCKED;
            status_d[i] = stp_pkg::ST_BLOCKING;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_mac_q  <= '0;
      root_pri_q  <= stp_pkg::OWN_PRI_RST;
      path_cost_q <= '0;
      rpv_q       <= 1'b0;
      rp_idx_q    <= '0;
      for (int i = 0; i < stp_pkg::NUM_PORTS; i++) begin
        role_q[i]   <= stp_pkg::ROLE_UNKNOWN;
        status_q[i] <= stp_pkg::ST_BLOCKING;
      end
    end else if (adv) begin
      root_mac_q  <= root_mac_d;
      root_pri_q  <= root_pri_d;
      path_cost_q <= path_cost_d;
      rpv_q       <= rpv_d;
      rp_idx_q    <= rp_idx_d;
      for (int i = 0; i < stp_pkg::NUM_PORTS; i++) begin
        role_q[i]   <= role_d[i];
        status_q[i] <= status_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [stp_pkg::VEC_W-1:0] role_vec_d, status_vec_d;

  always_comb begin
    role_vec_d   = '0;
    status_vec_d = '0;
    for (int i = 0; i < stp_pkg::VEC_PORTS; i++) begin
      role_vec_d[2*i +: 2]   = role_d[i];
      status_vec_d[2*i +: 2] = status_d[i];
    end
  end

  logic                        acc_q;
  logic [stp_pkg::VEC_W-1:0]   role_vec_q, status_vec_q;
  logic [stp_pkg::MAC_W-1:0]   out_mac_q;
  logic [stp_pkg::PRI_W-1:0]   out_pri_q;
  logic [stp_pkg::RCOST_W-1:0] out_cost_q;
  logic                        out_rpv_q;
  logic [stp_pkg::PORT_W-1:0]  out_rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      acc_q        <= acc_d;
      out_mac_q    <= root_mac_d;
      out_pri_q    <= root_pri_d;
      out_cost_q   <= path_cost_d;
      out_rpv_q    <= rpv_d;
      out_rp_q     <= rpv_d ? rp_idx_d : '0;
      role_vec_q   <= role_vec_d;
      status_vec_q <= status_vec_d;
    end
  end

  assign out_ch.valid             = out_valid_q;
  assign out_ch.accepted          = acc_q;
  assign out_ch.cur_root_mac      = out_mac_q;
  assign out_ch.cur_root_priority = out_pri_q;
  assign out_ch.cur_root_cost     = out_cost_q;
  assign out_ch.has_root_port     = out_rpv_q;
  assign out_ch.cur_root_port     = out_rp_q;
  assign out_ch.role_vector       = role_vec_q;
  assign out_ch.status_vector     = status_vec_q;

endmodule

[hdl/stp_prio_cmp.sv]
// Lexicographic priority vector compare, lower wins at each field.
// Depends on stp_pkg (prio_vec_t).
module stp_prio_cmp (
  input  stp_pkg::prio_vec_t cand_i,
  input  stp_pkg::prio_vec_t cur_i,
  output logic               better_o
);

  always_comb begin
    if (cand_i.rt_pri != cur_i.rt_pri) begin
      better_o = cand_i.rt_pri < cur_i.rt_pri;
    end else if (cand_i.rt_mac != cur_i.rt_mac) begin
      better_o = cand_i.rt_mac < cur_i.rt_mac;
    end else if (cand_i.cost != cur_i.cost) begin
      better_o = cand_i.cost < cur_i.cost;
    end else if (cand_i.br_pri != cur_i.br_pri) begin
      better_o = cand_i.br_pri < cur_i.br_pri;
    end else begin
      better_o = cand_i.br_mac < cur_i.br_mac;
    end
  end

endmodule

[bench/stp_bpdu_root_election_test.sv]
// Self-checking testbench for stp_bpdu_root_election.
// Predicts every result from a mirror of the election state and scores it field by field.
// Depends on stp_pkg, stp_in_if/stp_out_if and the stp_bpdu_root_election RTL.
module stp_bpdu_root_election_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int RES_LAT    = 1;          // extra wait in drain() after the queues empty
  localparam int TIMEOUT_NS = 2_000_000;  // far above the slowest legal run
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 125;

  // a few MACs shared by many BPDUs so that the vector compare hits ties
  localparam logic [stp_pkg::MAC_W-1:0] MAC_A = 48'h0200_0000_0010;
  localparam logic [stp_pkg::MAC_W-1:0] MAC_B = 48'h0200_0000_0020;

  typedef struct packed {
    stp_pkg::cmd_e               cmd;
    logic [stp_pkg::PORT_W-1:0]  rx_port;
    logic [stp_pkg::PRI_W-1:0]   rt_pri;
    logic [stp_pkg::MAC_W-1:0]   rt_mac;
    logic [stp_pkg::RCOST_W-1:0] rt_cost;
    logic [stp_pkg::PRI_W-1:0]   snd_pri;
    logic [stp_pkg::MAC_W-1:0]   snd_mac;
  } bpdu_item_t;

  typedef struct packed {
    logic                        accepted;
    logic [stp_pkg::MAC_W-1:0]   rt_mac;
    logic [stp_pkg::PRI_W-1:0]   rt_pri;
    logic [stp_pkg::RCOST_W-1:0] rt_cost;
    logic                        has_rp;
    logic [stp_pkg::PORT_W-1:0]  rp;
    logic [stp_pkg::VEC_W-1:0]   roles;
    logic [stp_pkg::VEC_W-1:0]   stats;
  } election_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [stp_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [stp_pkg::CFG_W-1:0]     cfg_wdata_i;

  stp_in_if  bpdu_ch ();
  stp_out_if res_ch ();

  stp_bpdu_root_election dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (bpdu_ch),
    .out_ch      (res_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Mirror of the bridge: register copies and election state
  // ---------------------------------------------------------------------------
  logic [stp_pkg::MAC_W-1:0]   cfg_own_mac;
  logic [stp_pkg::PRI_W-1:0]   cfg_own_pri;
  logic [stp_pkg::PIU_W-1:0]   cfg_ports;
  logic [stp_pkg::TABLE_W-1:0] cfg_costs;

  logic [stp_pkg::MAC_W-1:0]   est_root_mac;
  logic [stp_pkg::PRI_W-1:0]   est_root_pri;
  logic [stp_pkg::RCOST_W-1:0] est_cost;
  logic                        est_rp_valid;
  logic [stp_pkg::PORT_W-1:0]  est_rp_idx;
  stp_pkg::role_e              est_role   [stp_pkg::NUM_PORTS];
  stp_pkg::status_e            est_status [stp_pkg::NUM_PORTS];

  bpdu_item_t       bpdu_q[$];    // BPDUs/commands not yet taken by the block
  election_result_t expect_q[$];  // predicted results, oldest first

  int unsigned gap_pct = 11;  // idle percentage on both channels
  bit          bpdu_taken;    // input transaction at the last rising edge
  int          mismatches;
  int          n_sent, n_checked, n_adopted, n_settings;

  // Role pass on recompute or after a change of root: own bridge as root makes every live
  // port designated/forwarding; otherwise all live ports but the root port go blocked.
  function automatic void settle_roles(int unsigned n);
    if (est_root_mac == cfg_own_mac && est_root_pri == cfg_own_pri) begin
      est_rp_valid = 1'b0;
      est_rp_idx   = '0;
      for (int i = 0; i < n; i++) begin
        est_role[i]   = stp_pkg::ROLE_DESIGNATED;
        est_status[i] = stp_pkg::ST_FORWARDING;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!(est_rp_valid && i == est_rp_idx)) begin
          est_role[i]   = stp_pkg::ROLE_BLOCKED;
          est_status[i] = stp_pkg::ST_BLOCKING;
        end
      end
    end
  endfunction

  // Advances the mirror by one command and returns the result it produces.
  function automatic election_result_t predict_election(bpdu_item_t it);
    election_result_t              r;
    int unsigned                   n;
    int unsigned                   sh;
    logic [stp_pkg::TABLE_W-1:0]   port_cost;
    logic [stp_pkg::RCOST_W+1:0]   sum;
    logic [stp_pkg::RCOST_W-1:0]   total;
    stp_pkg::prio_vec_t            rx_vec, held_vec;
    r = '0;
    n = (cfg_ports > stp_pkg::NUM_PORTS) ? stp_pkg::NUM_PORTS : int'(cfg_ports);
    case (it.cmd)
      stp_pkg::CMD_INIT: begin
        est_root_mac = cfg_own_mac;
        est_root_pri = cfg_own_pri;
        est_cost     = '0;
        est_rp_valid = 1'b0;
        est_rp_idx   = '0;
        for (int i = 0; i < n; i++) begin
          est_role[i]   = stp_pkg::ROLE_UNKNOWN;
          est_status[i] = stp_pkg::ST_BLOCKING;
        end
      end
      stp_pkg::CMD_RX_BPDU: begin
        // ports outside the live range are dropped silently
        if (it.rx_port < n) begin
          sh        = it.rx_port * stp_pkg::COST_WIDTH;
          port_cost = (sh >= stp_pkg::TABLE_W) ? '0
                    : (cfg_costs >> sh)
                      & ((stp_pkg::TABLE_W'(1) << stp_pkg::COST_WIDTH) - stp_pkg::TABLE_W'(1));
          sum   = (stp_pkg::RCOST_W+2)'(it.rt_cost) + (stp_pkg::RCOST_W+2)'(port_cost);
          total = (|sum[stp_pkg::RCOST_W+1:stp_pkg::RCOST_W]) ? {stp_pkg::RCOST_W{1'b1}}
                                                              : sum[stp_pkg::RCOST_W-1:0];
          // packed compare of the vectors is the lexicographic order
          rx_vec   = {it.rt_pri, it.rt_mac, total, it.snd_pri, it.snd_mac};
          held_vec = {est_root_pri, est_root_mac, est_cost, cfg_own_pri, cfg_own_mac};
          if (rx_vec < held_vec) begin
            est_root_mac           = it.rt_mac;
            est_root_pri           = it.rt_pri;
            est_cost               = total;
            est_rp_valid           = 1'b1;
            est_rp_idx             = it.rx_port;
            est_role[it.rx_port]   = stp_pkg::ROLE_ROOT;
            est_status[it.rx_port] = stp_pkg::ST_FORWARDING;
            settle_roles(n);
            r.accepted = 1'b1;
          end
        end
      end
      stp_pkg::CMD_RECOMPUTE: settle_roles(n);
      default: begin
        for (int i = 0; i < n; i++) est_status[i] = stp_pkg::ST_DISABLED;
      end
    endcase
    r.rt_mac  = est_root_mac;
    r.rt_pri  = est_root_pri;
    r.rt_cost = est_cost;
    r.has_rp  = est_rp_valid;
    r.rp      = est_rp_valid ? est_rp_idx : '0;
    for (int i = 0; i < stp_pkg::VEC_PORTS; i++) begin
      r.roles[2*i +: 2] = est_role[i];
      r.stats[2*i +: 2] = est_status[i];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge; valid holds until the
  // transaction goes through
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= gap_pct);
    if (!bpdu_ch.valid || bpdu_taken) begin
      if (bpdu_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        bpdu_ch.valid                <= 1'b1;
        bpdu_ch.cmd                  <= bpdu_q[0].cmd;
        bpdu_ch.rx_port              <= bpdu_q[0].rx_port;
        bpdu_ch.bpdu_root_priority   <= bpdu_q[0].rt_pri;
        bpdu_ch.bpdu_root_mac        <= bpdu_q[0].rt_mac;
        bpdu_ch.bpdu_root_cost       <= bpdu_q[0].rt_cost;
        bpdu_ch.bpdu_sender_priority <= bpdu_q[0].snd_pri;
        bpdu_ch.bpdu_sender_mac      <= bpdu_q[0].snd_mac;
      end else begin
        bpdu_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on the rising edge, predict each input transaction and score
  // each output transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    election_result_t seen, want;
    bpdu_taken = rst_ni && bpdu_ch.valid && bpdu_ch.ready;
    if (bpdu_taken) begin
      expect_q.push_back(predict_election(bpdu_q.pop_front()));
      n_sent++;
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      seen = {res_ch.accepted, res_ch.cur_root_mac, res_ch.cur_root_priority,
              res_ch.cur_root_cost, res_ch.has_root_port, res_ch.cur_root_port,
              res_ch.role_vector, res_ch.status_vector};
      if (expect_q.size() == 0) begin
        $error("result transaction with no prediction pending");
        mismatches++;
      end else begin
        want = expect_q.pop_front();
        n_checked++;
        if (want.accepted) n_adopted++;
        check_field("accepted",          64'(want.accepted), 64'(seen.accepted));
        check_field("cur_root_mac",      64'(want.rt_mac),   64'(seen.rt_mac));
        check_field("cur_root_priority", 64'(want.rt_pri),   64'(seen.rt_pri));
        check_field("cur_root_cost",     64'(want.rt_cost),  64'(seen.rt_cost));
        check_field("has_root_port",     64'(want.has_rp),   64'(seen.has_rp));
        check_field("cur_root_port",     64'(want.rp),       64'(seen.rp));
        check_field("role_vector",       64'(want.roles),    64'(seen.roles));
        check_field("status_vector",     64'(want.stats),    64'(seen.stats));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_bpdu(stp_pkg::cmd_e cmd, logic [stp_pkg::PORT_W-1:0] port,
                            logic [stp_pkg::PRI_W-1:0] rp, logic [stp_pkg::MAC_W-1:0] rm,
                            logic [stp_pkg::RCOST_W-1:0] rc,
                            logic [stp_pkg::PRI_W-1:0] sp, logic [stp_pkg::MAC_W-1:0] sm);
    bpdu_q.push_back('{cmd, port, rp, rm, rc, sp, sm});
  endtask

  // Waits until every queued item is taken and every result scored, plus a settling margin.
  task automatic drain();
    while (bpdu_q.size() != 0 || expect_q.size() != 0) @(posedge clk_i);
    repeat (RES_LAT + 2) @(posedge clk_i);
  endtask

  // Register write; only called with the block idle, so the mirror follows at once.
  task automatic write_cfg(stp_pkg::cfg_idx_e idx, logic [stp_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      stp_pkg::CFG_OWN_MAC: cfg_own_mac = val[stp_pkg::MAC_W-1:0];
      stp_pkg::CFG_OWN_PRI: cfg_own_pri = val[stp_pkg::PRI_W-1:0];
      stp_pkg::CFG_PORTS:   cfg_ports   = val[stp_pkg::PIU_W-1:0];
      default:              cfg_costs   = val[stp_pkg::TABLE_W-1:0];
    endcase
  endtask

  // Field pools lean on the own bridge and a few shared values so that ties
  // reach the deeper compare stages; one pick in six is fully random.
  function automatic logic [stp_pkg::MAC_W-1:0] pick_mac();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(5))
      0:       return cfg_own_mac;
      1:       return MAC_A;
      2:       return MAC_B;
      3:       return '0;
      4:       return '1;
      default: return r[stp_pkg::MAC_W-1:0];
    endcase
  endfunction

  function automatic logic [stp_pkg::PRI_W-1:0] pick_pri();
    case ($urandom_range(5))
      0:       return cfg_own_pri;
      1:       return 16'h8000;
      2:       return 16'h7FFF;
      3:       return '0;
      4:       return '1;
      default: return stp_pkg::PRI_W'($urandom());
    endcase
  endfunction

  function automatic logic [stp_pkg::RCOST_W-1:0] pick_cost();
    case ($urandom_range(3))
      0, 1:    return stp_pkg::RCOST_W'($urandom_range(64));
      2:       return 32'hFFFF_FF00 | stp_pkg::RCOST_W'($urandom_range(255));
      default: return stp_pkg::RCOST_W'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned   k;
    stp_pkg::cmd_e c;
    logic [63:0]   costs;

    rst_ni                       = 1'b0;
    cfg_we_i                     = 1'b0;
    cfg_idx_i                    = stp_pkg::CFG_OWN_MAC;
    cfg_wdata_i                  = '0;
    bpdu_ch.valid                = 1'b0;
    bpdu_ch.cmd                  = stp_pkg::CMD_INIT;
    bpdu_ch.rx_port              = '0;
    bpdu_ch.bpdu_root_priority   = '0;
    bpdu_ch.bpdu_root_mac        = '0;
    bpdu_ch.bpdu_root_cost       = '0;
    bpdu_ch.bpdu_sender_priority = '0;
    bpdu_ch.bpdu_sender_mac      = '0;
    res_ch.ready                 = 1'b0;

    // mirror of the reset state
    cfg_own_mac  = '0;
    cfg_own_pri  = stp_pkg::OWN_PRI_RST;
    cfg_ports    = stp_pkg::PORTS_RST;
    cfg_costs    = '0;
    est_root_mac = '0;
    est_root_pri = stp_pkg::OWN_PRI_RST;
    est_cost     = '0;
    est_rp_valid = 1'b0;
    est_rp_idx   = '0;
    for (int i = 0; i < stp_pkg::NUM_PORTS; i++) begin
      est_role[i]   = stp_pkg::ROLE_UNKNOWN;
      est_status[i] = stp_pkg::ST_BLOCKING;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset configuration: own bridge 32768 / MAC 0, 4 ports, zero costs.
    queue_bpdu(stp_pkg::CMD_RECOMPUTE, 2'd0, '0, '0, '0, '0, '0);  // own bridge is root
    queue_bpdu(stp_pkg::CMD_DISABLE,   2'd0, '0, '0, '0, '0, '0);
    // vector identical to our own: not better
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd1, 16'h8000, '0, '0, 16'h8000, '0);
    // same root as ours, lower sender priority: adopted, yet root is still self
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd0, 16'h8000, '0, '0, 16'h7FFF, MAC_B);
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd2, 16'h7FFF, '1, '1, '1, '1);  // lower root priority
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd3, 16'h7FFF, '1, 32'hFFFF_FFFE, '1, '1);  // lower cost
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd1, 16'h7FFF, '1, 32'hFFFF_FFFE, '1,
               48'hFFFF_FFFF_FFFE);
    queue_bpdu(stp_pkg::CMD_RECOMPUTE, 2'd3, '1, '1, '1, '1, '1);
    queue_bpdu(stp_pkg::CMD_DISABLE,   2'd2, '1, '1, '1, '1, '1);
    queue_bpdu(stp_pkg::CMD_RX_BPDU,   2'd0, '0, '0, '0, '0, '0);
    queue_bpdu(stp_pkg::CMD_INIT,      2'd1, '1, '1, '1, '1, '1);
    drain();

    // Extremes: one live port, full cost table, all-ones bridge identity.
    write_cfg(stp_pkg::CFG_OWN_MAC, '1);
    write_cfg(stp_pkg::CFG_OWN_PRI, '1);
    write_cfg(stp_pkg::CFG_PORTS, 64'd1);
    write_cfg(stp_pkg::CFG_COST_TABLE, '1);
    n_settings++;
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd1, '0, '0, '0, '0, '0);  // port outside live range
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd3, '0, '0, '0, '0, '0);
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd0, '0, '0, '1, '1, '1);  // cost saturates
    // equal cost, sender wins
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd0, '0, '0, 32'hFFFF_0000, '0, '1);
    // sender equals own
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd0, '0, '0, 32'hFFFF_0000, '1, '1);
    queue_bpdu(stp_pkg::CMD_RECOMPUTE, 2'd0, '0, '0, '0, '0, '0);
    queue_bpdu(stp_pkg::CMD_DISABLE,   2'd0, '0, '0, '0, '0, '0);
    queue_bpdu(stp_pkg::CMD_INIT,      2'd0, '0, '0, '0, '0, '0);
    drain();

    // Port count above the port total saturates; distinct per-port costs.
    write_cfg(stp_pkg::CFG_PORTS, 64'd7);
    write_cfg(stp_pkg::CFG_COST_TABLE, {16'd3, 16'd2, 16'd1, 16'd0});
    n_settings++;
    queue_bpdu(stp_pkg::CMD_RX_BPDU, 2'd3, 16'h1000, MAC_A, 32'd10, '1, '1);
    drain();

    // Make the adopted root our own identity: recompute and a better path
    // to ourselves both end with no root port.
    write_cfg(stp_pkg::CFG_OWN_PRI, 64'h1000);
    write_cfg(stp_pkg::CFG_OWN_MAC, 64'(MAC_A));
    n_settings++;
    queue_bpdu(stp_pkg::CMD_RECOMPUTE, 2'd0, '0, '0, '0, '0, '0);
    queue_bpdu(stp_pkg::CMD_RX_BPDU,   2'd1, 16'h1000, MAC_A, '0, 16'h1000, MAC_B);
    queue_bpdu(stp_pkg::CMD_DISABLE,   2'd0, '0, '0, '0, '0, '0);
    drain();

    // Random phases, a new register setting each; one phase runs without gaps.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      gap_pct = (ph == 2) ? 0 : 11;
      for (int p = 0; p < 4; p++) costs[16*p +: 16] = 16'($urandom_range(255));
      if (ph == 3) costs = {$urandom(), $urandom()};
      write_cfg(stp_pkg::CFG_OWN_MAC, 64'(pick_mac()));
      write_cfg(stp_pkg::CFG_OWN_PRI, 64'(pick_pri()));
      case (ph)
        0, 4:    write_cfg(stp_pkg::CFG_PORTS, 64'd4);
        1:       write_cfg(stp_pkg::CFG_PORTS, 64'd1);
        2:       write_cfg(stp_pkg::CFG_PORTS, 64'd3);
        3:       write_cfg(stp_pkg::CFG_PORTS, 64'd2);
        default: write_cfg(stp_pkg::CFG_PORTS, 64'($urandom_range(1, 4)));
      endcase
      write_cfg(stp_pkg::CFG_COST_TABLE, costs);
      n_settings++;
      for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
        k = $urandom_range(99);
        if (k < 4)       c = stp_pkg::CMD_INIT;
        else if (k < 12) c = stp_pkg::CMD_RECOMPUTE;
        else if (k < 18) c = stp_pkg::CMD_DISABLE;
        else             c = stp_pkg::CMD_RX_BPDU;
        queue_bpdu(c, stp_pkg::PORT_W'($urandom_range(3)), pick_pri(), pick_mac(),
                   pick_cost(), pick_pri(), pick_mac());
      end
      drain();
    end

    $display("Sent %0d transactions over %0d register settings; %0d results checked,",
             n_sent, n_settings, n_checked);
    $display("%0d BPDUs adopted as better, %0d mismatches.", n_adopted, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a stuck handshake ends the run here.
  initial begin
    #(TIMEOUT_NS);
    $error("timeout: %0d transactions pending, %0d results outstanding",
           bpdu_q.size(), expect_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
